// ===== rtl/core/spi_flash_command_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// spi_flash_command_sequencer_macros.svh
// Assertion macros shared by the sequencer checker.
// ---------------------------------------------------------------------------
`ifndef SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcs assertion failed");

// Next-cycle implication, disabled during reset.
`define SFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcs assertion failed");

`endif

// ===== rtl/core/sfcs_pkg.sv =====
// ---------------------------------------------------------------------------
// sfcs_pkg
// Types, constants and command tables of the SPI flash command sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package sfcs_pkg;

    // Stored widths of the flash address and fast-read length.
    localparam int ADDR_BITS = 24;
    localparam int LEN_BITS  = 16;

    // Fixed port field widths.
    localparam int ADDR_FIELD_W = 24;
    localparam int HOST_W       = 16;

    // Command queue between front and back.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    // Flash opcodes.
    localparam logic [7:0] FL_RDSR  = 8'h05;
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_WRDI  = 8'h04;
    localparam logic [7:0] FL_WRSR  = 8'h01;
    localparam logic [7:0] FL_RDID  = 8'h90;
    localparam logic [7:0] FL_SE    = 8'h20;
    localparam logic [7:0] FL_PP    = 8'h02;
    localparam logic [7:0] FL_FREAD = 8'h0B;
    localparam logic [7:0] FL_DUMMY = 8'h00;

    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [LEN_BITS-1:0]     len_t;
    typedef logic [ADDR_FIELD_W-1:0] addr_field_t;
    typedef logic [QPTR_BITS-1:0]    qptr_t;
    typedef logic [QPTR_BITS:0]      qcnt_t;

    typedef enum logic [2:0] {
        OP_STATUS,
        OP_WEN,
        OP_WDIS,
        OP_WSR,
        OP_ID,
        OP_ERASE,
        OP_PROGRAM,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEQ,
        PH_DATA,
        PH_POLL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BUS,
        KIND_DATA,
        KIND_DONE
    } kind_t;

    // Classified input transaction as held in the queue.
    typedef struct packed {
        logic       is_reply;
        op_t        op;
        addr_t      addr;
        logic [7:0] value;
        len_t       len;
        logic [7:0] reply;
    } entry_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        tx;
        logic              rel;
        logic [HOST_W-1:0] host;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       rel;
    } bus_byte_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Number of transfers in the fixed part of each command.
    function automatic logic [3:0] seq_len(op_t op);
        logic [3:0] n;
        unique case (op)
            OP_STATUS:  n = 4'd2;
            OP_WEN:     n = 4'd1;
            OP_WDIS:    n = 4'd1;
            OP_WSR:     n = 4'd2;
            OP_ID:      n = 4'd9;
            OP_ERASE:   n = 4'd5;
            OP_PROGRAM: n = 4'd6;
            OP_READ:    n = 4'd5;
        endcase
        return n;
    endfunction

    // Bus byte and chip select release of transfer idx of the fixed part.
    function automatic bus_byte_t seq_byte(op_t op, logic [3:0] idx, addr_field_t addr,
                                           logic [7:0] held, logic len_zero);
        bus_byte_t b;
        b.data = FL_DUMMY;
        b.rel  = 1'b0;
        unique case (op)
            OP_STATUS:
            begin
                b.data = (idx == 4'd1) ? FL_DUMMY : FL_RDSR;
                b.rel  = (idx == 4'd1);
            end
            OP_WEN:
            begin
                b.data = FL_WREN;
                b.rel  = 1'b1;
            end
            OP_WDIS:
            begin
                b.data = FL_WRDI;
                b.rel  = 1'b1;
            end
            OP_WSR:
            begin
                b.data = (idx == 4'd1) ? held : FL_WRSR;
                b.rel  = (idx == 4'd1);
            end
            OP_ID:
            begin
                unique case (idx)
                    4'd0:
                    begin
                        b.data = FL_WREN;
                        b.rel  = 1'b1;
                    end
                    4'd1:    b.data = FL_WRSR;
                    4'd2:    b.rel  = 1'b1;
                    4'd3:    b.data = FL_RDID;
                    default: b.rel  = (idx == 4'd8);
                endcase
            end
            OP_ERASE:
            begin
                unique case (idx)
                    4'd0:
                    begin
                        b.data = FL_WREN;
                        b.rel  = 1'b1;
                    end
                    4'd1:    b.data = FL_SE;
                    4'd2:    b.data = addr[23:16];
                    4'd3:    b.data = addr[15:8];
                    default:
                    begin
                        b.data = addr[7:0];
                        b.rel  = 1'b1;
                    end
                endcase
            end
            OP_PROGRAM:
            begin
                unique case (idx)
                    4'd0:
                    begin
                        b.data = FL_WREN;
                        b.rel  = 1'b1;
                    end
                    4'd1:    b.data = FL_PP;
                    4'd2:    b.data = addr[23:16];
                    4'd3:    b.data = addr[15:8];
                    4'd4:    b.data = addr[7:0];
                    default:
                    begin
                        b.data = held;
                        b.rel  = 1'b1;
                    end
                endcase
            end
            OP_READ:
            begin
                unique case (idx)
                    4'd0:    b.data = FL_FREAD;
                    4'd1:    b.data = addr[23:16];
                    4'd2:    b.data = addr[15:8];
                    4'd3:    b.data = addr[7:0];
                    default: b.rel  = len_zero;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfcs_in_if.sv =====
// ---------------------------------------------------------------------------
// sfcs_in_if
// Request channel: host commands and flash reply bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfcs_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  command;
    logic [23:0] address;
    logic [7:0]  write_value;
    logic [15:0] read_length;
    logic [7:0]  reply_byte;

    modport source (
        output valid, req_type, command, address, write_value, read_length, reply_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, command, address, write_value, read_length, reply_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/sfcs_out_if.sv =====
// ---------------------------------------------------------------------------
// sfcs_out_if
// Result channel: bus transfers, host data and completion.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfcs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic        release_after;
    logic [15:0] host_value;
    logic        last;

    modport source (
        output valid, out_kind, tx_byte, release_after, host_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, tx_byte, release_after, host_value, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/sfcs_front.sv =====
// ---------------------------------------------------------------------------
// sfcs_front
// Accepts request transactions, classifies and masks them into queue entries.
// ---------------------------------------------------------------------------
`default_nettype none

module sfcs_front (
    sfcs_in_if.sink              request,
    input  sfcs_pkg::q_status_t  q_status,
    output logic                 push,
    output sfcs_pkg::entry_t     push_data
);

    assign request.ready = !q_status.full;
    assign push          = request.valid && !q_status.full;

    always_comb
    begin
        push_data.is_reply = request.req_type;
        push_data.op       = sfcs_pkg::op_t'(request.command);
        push_data.addr     = sfcs_pkg::addr_t'(request.address);
        push_data.value    = request.write_value;
        push_data.len      = sfcs_pkg::len_t'(request.read_length);
        push_data.reply    = request.reply_byte;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfcs_queue.sv =====
// ---------------------------------------------------------------------------
// sfcs_queue
// Small FIFO of classified entries between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module sfcs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfcs_pkg::entry_t     push_data,
    input  logic                 pop,
    output sfcs_pkg::entry_t     pop_data,
    output sfcs_pkg::q_status_t  q_status
);

    sfcs_pkg::entry_t  slot_reg [sfcs_pkg::QDEPTH];
    sfcs_pkg::qptr_t   wr_ptr_reg, wr_ptr_next;
    sfcs_pkg::qptr_t   rd_ptr_reg, rd_ptr_next;
    sfcs_pkg::qcnt_t   count_reg, count_next;

    function automatic sfcs_pkg::qptr_t bump(sfcs_pkg::qptr_t p);
        return (p == sfcs_pkg::qptr_t'(sfcs_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_status.full  = (count_reg == sfcs_pkg::qcnt_t'(sfcs_pkg::QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfcs_back.sv =====
// ---------------------------------------------------------------------------
// sfcs_back
// Command sequencer: retires one queue entry per cycle unless output stalls,
// emits results via an output register, one pending slot for a second result.
// ---------------------------------------------------------------------------
`default_nettype none

module sfcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfcs_pkg::entry_t     pop_data,
    input  sfcs_pkg::q_status_t  q_status,
    output logic                 pop,
    sfcs_out_if.source           result
);

    sfcs_pkg::phase_t   phase_reg, phase_next;
    sfcs_pkg::op_t      op_reg, op_next;
    sfcs_pkg::addr_t    target_reg, target_next;
    logic [7:0]         held_reg, held_next;
    sfcs_pkg::len_t     bytes_left_reg, bytes_left_next;
    logic [3:0]         byte_index_reg, byte_index_next;
    logic [7:0]         maker_id_reg, maker_id_next;
    logic               polling_busy_reg, polling_busy_next;

    sfcs_pkg::result_t  out_reg, pend_reg;
    logic               out_valid_reg, pend_valid_reg;

    sfcs_pkg::result_t  r0, r1;
    logic               r0_valid, r1_valid;

    logic               slot_free;
    logic [3:0]         idx_inc;
    logic               seq_more;
    sfcs_pkg::len_t     bytes_dec;
    sfcs_pkg::entry_t   e;

    function automatic sfcs_pkg::result_t bus_res(sfcs_pkg::bus_byte_t b, logic last);
        sfcs_pkg::result_t r;
        r      = '0;
        r.kind = sfcs_pkg::KIND_BUS;
        r.tx   = b.data;
        r.rel  = b.rel;
        r.last = last;
        return r;
    endfunction

    function automatic sfcs_pkg::result_t host_res(sfcs_pkg::kind_t k,
                                                   logic [sfcs_pkg::HOST_W-1:0] v,
                                                   logic last);
        sfcs_pkg::result_t r;
        r      = '0;
        r.kind = k;
        r.host = v;
        r.last = last;
        return r;
    endfunction

    assign e         = pop_data;
    assign slot_free = !out_valid_reg || result.ready;
    assign pop       = slot_free && !pend_valid_reg && !q_status.empty;
    assign idx_inc   = byte_index_reg + 4'd1;
    assign seq_more  = (idx_inc < sfcs_pkg::seq_len(op_reg));
    assign bytes_dec = bytes_left_reg - 1'b1;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (!e.is_reply)
        begin
            if (phase_reg == sfcs_pkg::PH_IDLE)
                phase_next = sfcs_pkg::PH_SEQ;
        end
        else
        begin
            unique case (phase_reg)
                sfcs_pkg::PH_IDLE: phase_next = sfcs_pkg::PH_IDLE;
                sfcs_pkg::PH_SEQ:
                begin
                    if (!seq_more)
                    begin
                        unique case (op_reg)
                            sfcs_pkg::OP_ERASE,
                            sfcs_pkg::OP_PROGRAM: phase_next = sfcs_pkg::PH_POLL;
                            sfcs_pkg::OP_READ:
                                phase_next = (bytes_left_reg != '0) ? sfcs_pkg::PH_DATA
                                                                    : sfcs_pkg::PH_POLL;
                            default:              phase_next = sfcs_pkg::PH_IDLE;
                        endcase
                    end
                end
                sfcs_pkg::PH_DATA:
                begin
                    if (bytes_dec == '0)
                        phase_next = sfcs_pkg::PH_POLL;
                end
                sfcs_pkg::PH_POLL:
                begin
                    if (polling_busy_reg && !e.reply[0])
                        phase_next = sfcs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Results and datapath state.
    always_comb
    begin
        r0                = '0;
        r1                = '0;
        r0_valid          = 1'b0;
        r1_valid          = 1'b0;
        op_next           = op_reg;
        target_next       = target_reg;
        held_next         = held_reg;
        bytes_left_next   = bytes_left_reg;
        byte_index_next   = byte_index_reg;
        maker_id_next     = maker_id_reg;
        polling_busy_next = polling_busy_reg;
        if (!e.is_reply)
        begin
            if (phase_reg == sfcs_pkg::PH_IDLE)
            begin
                op_next           = e.op;
                target_next       = e.addr;
                held_next         = e.value;
                bytes_left_next   = e.len;
                byte_index_next   = '0;
                polling_busy_next = 1'b0;
                r0_valid          = 1'b1;
                r0 = bus_res(sfcs_pkg::seq_byte(e.op, 4'd0,
                                                sfcs_pkg::addr_field_t'(e.addr),
                                                e.value, e.len == '0), 1'b1);
            end
        end
        else
        begin
            unique case (phase_reg)
                sfcs_pkg::PH_IDLE:
                begin
                    r0_valid = 1'b0;
                end
                sfcs_pkg::PH_SEQ:
                begin
                    if (op_reg == sfcs_pkg::OP_ID && byte_index_reg == 4'd7)
                        maker_id_next = e.reply;
                    byte_index_next = idx_inc;
                    r0_valid        = 1'b1;
                    if (seq_more)
                        r0 = bus_res(sfcs_pkg::seq_byte(op_reg, idx_inc,
                                                        sfcs_pkg::addr_field_t'(target_reg),
                                                        held_reg, bytes_left_reg == '0),
                                     1'b1);
                    else
                    begin
                        unique case (op_reg)
                            sfcs_pkg::OP_STATUS:
                            begin
                                r0 = host_res(sfcs_pkg::KIND_DATA, {8'd0, e.reply}, 1'b0);
                                r1 = host_res(sfcs_pkg::KIND_DONE, {8'd0, e.reply}, 1'b1);
                                r1_valid = 1'b1;
                            end
                            sfcs_pkg::OP_ID:
                            begin
                                r0 = host_res(sfcs_pkg::KIND_DATA, {maker_id_reg, e.reply},
                                              1'b0);
                                r1 = host_res(sfcs_pkg::KIND_DONE, {maker_id_reg, e.reply},
                                              1'b1);
                                r1_valid = 1'b1;
                            end
                            sfcs_pkg::OP_WEN,
                            sfcs_pkg::OP_WDIS,
                            sfcs_pkg::OP_WSR:
                                r0 = host_res(sfcs_pkg::KIND_DONE, '0, 1'b1);
                            sfcs_pkg::OP_READ:
                            begin
                                if (bytes_left_reg != '0)
                                    r0 = bus_res('{data: sfcs_pkg::FL_DUMMY,
                                                   rel: bytes_left_reg == sfcs_pkg::len_t'(1)},
                                                 1'b1);
                                else
                                begin
                                    r0 = bus_res('{data: sfcs_pkg::FL_RDSR, rel: 1'b0}, 1'b1);
                                    polling_busy_next = 1'b0;
                                end
                            end
                            sfcs_pkg::OP_ERASE,
                            sfcs_pkg::OP_PROGRAM:
                            begin
                                r0 = bus_res('{data: sfcs_pkg::FL_RDSR, rel: 1'b0}, 1'b1);
                                polling_busy_next = 1'b0;
                            end
                        endcase
                    end
                end
                sfcs_pkg::PH_DATA:
                begin
                    r0 = host_res(sfcs_pkg::KIND_DATA, {8'd0, e.reply}, 1'b0);
                    r0_valid        = 1'b1;
                    r1_valid        = 1'b1;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec != '0)
                        r1 = bus_res('{data: sfcs_pkg::FL_DUMMY,
                                       rel: bytes_dec == sfcs_pkg::len_t'(1)}, 1'b1);
                    else
                    begin
                        r1 = bus_res('{data: sfcs_pkg::FL_RDSR, rel: 1'b0}, 1'b1);
                        polling_busy_next = 1'b0;
                    end
                end
                sfcs_pkg::PH_POLL:
                begin
                    r0_valid = 1'b1;
                    if (!polling_busy_reg)
                    begin
                        polling_busy_next = 1'b1;
                        r0 = bus_res('{data: sfcs_pkg::FL_DUMMY, rel: 1'b1}, 1'b1);
                    end
                    else if (e.reply[0])
                    begin
                        polling_busy_next = 1'b0;
                        r0 = bus_res('{data: sfcs_pkg::FL_RDSR, rel: 1'b0}, 1'b1);
                    end
                    else
                    begin
                        polling_busy_next = 1'b0;
                        r0 = host_res(sfcs_pkg::KIND_DONE, {8'd0, e.reply}, 1'b1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sfcs_pkg::PH_IDLE;
            op_reg           <= sfcs_pkg::OP_STATUS;
            target_reg       <= '0;
            held_reg         <= '0;
            bytes_left_reg   <= '0;
            byte_index_reg   <= '0;
            maker_id_reg     <= '0;
            polling_busy_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg        <= phase_next;
                op_reg           <= op_next;
                target_reg       <= target_next;
                held_reg         <= held_next;
                bytes_left_reg   <= bytes_left_next;
                byte_index_reg   <= byte_index_next;
                maker_id_reg     <= maker_id_next;
                polling_busy_reg <= polling_busy_next;
            end
            if (slot_free)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                else if (pop)
                begin
                    out_valid_reg  <= r0_valid;
                    pend_valid_reg <= r1_valid;
                end
                else
                    out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
            out_reg <= pend_valid_reg ? pend_reg : r0;
        if (pop)
            pend_reg <= r1;
    end

    assign result.valid         = out_valid_reg;
    assign result.out_kind      = out_reg.kind;
    assign result.tx_byte       = out_reg.tx;
    assign result.release_after = out_reg.rel;
    assign result.host_value    = out_reg.host;
    assign result.last          = out_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/spi_flash_command_sequencer.sv =====
// ---------------------------------------------------------------------------
// spi_flash_command_sequencer
// SPI NOR flash command sequencer, one full-duplex byte transfer per step.
// ---------------------------------------------------------------------------
// A host command (req_type 0) starts a flash command and yields its first bus
// transfer; every reply byte (req_type 1) moves the sequence on by one step.
// The request channel takes one transaction per cycle while the four-entry
// command queue has room. The back end retires one queue entry per cycle
// while the output register is free and its pending slot is empty; an entry
// that yields two results (data plus finish, or data plus the next bus
// transfer) parks the second in the pending slot of the output register.
// A request's first result goes through the queue and the output register.
// Host commands that arrive while a command runs and reply bytes that arrive
// while idle are consumed and produce no result.
`default_nettype none

module spi_flash_command_sequencer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfcs_in_if.sink    request,
    sfcs_out_if.source result
);

    // Front to queue.
    logic                 push;
    sfcs_pkg::entry_t     push_data;

    // Queue to back.
    logic                 pop;
    sfcs_pkg::entry_t     pop_data;
    sfcs_pkg::q_status_t  q_status;

    // Front: classifies each request transaction and masks its fields to the
    // stored widths; back-pressure comes only from the queue filling up.
    sfcs_front u_front (
        .request   (request),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: decouples acceptance from sequencing so a stalled result
    // channel does not stop the request side at once.
    sfcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Back: the command state machine (fixed byte sequence, fast-read data
    // phase, status polling) and the result output register.
    sfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .q_status  (q_status),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sfcs_checker.sv =====
// ---------------------------------------------------------------------------
// sfcs_checker
// Port-level checks of the sequencer result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "spi_flash_command_sequencer_macros.svh"

module sfcs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_kind,
    input wire logic [7:0]  rsp_tx,
    input wire logic        rsp_rel,
    input wire logic [15:0] rsp_host,
    input wire logic        rsp_last
);

    logic [27:0] rsp_payload;
    logic        kind_bus;
    logic        fields_clear;

    assign rsp_payload  = {rsp_kind, rsp_tx, rsp_rel, rsp_host, rsp_last};
    assign kind_bus     = (rsp_kind == sfcs_pkg::KIND_BUS);
    assign fields_clear = kind_bus ? (rsp_host == '0) : (rsp_tx == '0 && !rsp_rel);

    // Stalled result holds.
    `SFCS_ASSERT_NEXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // Only the three result kinds appear.
    `SFCS_ASSERT_NOW(a_kind, clk, rst_n, rsp_valid, rsp_kind <= sfcs_pkg::KIND_DONE)

    // Host data is always followed by another result; bus and finish close.
    `SFCS_ASSERT_NOW(a_last, clk, rst_n, rsp_valid, rsp_last == (rsp_kind != sfcs_pkg::KIND_DATA))

    // Unused fields of each kind are zero.
    `SFCS_ASSERT_NOW(a_zero, clk, rst_n, rsp_valid, fields_clear)

endmodule

bind spi_flash_command_sequencer sfcs_checker u_sfcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_kind  (result.out_kind),
    .rsp_tx    (result.tx_byte),
    .rsp_rel   (result.release_after),
    .rsp_host  (result.host_value),
    .rsp_last  (result.last)
);

`default_nettype wire
